>>> rtl/csr_graph_symmetrize_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef CSR_GRAPH_SYMMETRIZE_CORE_ASSERT_SVH
`define CSR_GRAPH_SYMMETRIZE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSYM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("csym: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSYM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("csym: next-cycle check failed");

`endif

>>> rtl/csym_pkg.sv
package csym_pkg;

  // Default sizes of the stores.
  localparam int unsigned MAX_ROWS_DEF  = 1024;
  localparam int unsigned MAX_EDGES_DEF = 4096;

  // Field widths of the ports.
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned ROWCNT_W   = 11;
  localparam int unsigned VAL_W      = 14;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SORTED    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_FETCH   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_ORDER     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_READY = 3'd4
  } status_e;

endpackage

>>> rtl/csym_ram.sv
module csym_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/csr_graph_symmetrize_core.sv
// Channel   Ports                                              Handshake
// command   start_i, op_i, src_row_i, dest_col_i               start_i & !busy_o
// result    valid_o, word_kind_o, word_value_o, last_word_o,   valid_o, one cycle
//           status_o
// config    cfg_we_i, cfg_idx_i, cfg_data_i                    cfg_we_i
//
// A load leaves the core idle; any status beat shows the cycle after acceptance.
// An accepted fetch keeps busy high for one cycle while the result memories are
// read; its beat is registered in S_FETCH. A refused fetch stays idle and returns a not-ready beat.
// A compute filters the edges, clears the count stores, counts rows and columns,
// takes prefix sums, scatters to the transpose, sorts rows with a second scatter
// unless they are flagged sorted, and merges row by row; the count and each
// scatter are read-modify-write passes.
// Reset is asynchronous and clears control state only; no clearing pass runs.
// The receiver cannot stall results, so each beat is shown exactly once.
module csr_graph_symmetrize_core import csym_pkg::*; #(
  parameter int unsigned MAX_ROWS  = MAX_ROWS_DEF,
  parameter int unsigned MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [IDX_W-1:0]      src_row_i,
  input  logic [IDX_W-1:0]      dest_col_i,
  output logic                  valid_o,
  output logic                  word_kind_o,
  output logic [VAL_W-1:0]      word_value_o,
  output logic                  last_word_o,
  output logic [STAT_W-1:0]     status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned RA  = $clog2(MAX_ROWS + 1);
  localparam int unsigned NW  = RA;
  localparam int unsigned RCW = NW + 1;
  localparam int unsigned EA  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned OA  = $clog2(2 * MAX_EDGES);
  localparam int unsigned OW  = $clog2(2 * MAX_EDGES + 1);
  localparam int unsigned PW  = $clog2(MAX_ROWS + 2 * MAX_EDGES + 2);
  localparam int unsigned PRW = 2 * IDX_W;

  typedef enum logic [1:0] {
    PH_LOADING,
    PH_READY,
    PH_DONE
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FETCH,
    S_FILT,
    S_CLR,
    S_CNT_RD,
    S_CNT_ST,
    S_CNT_WR,
    S_PFX,
    S_SCT_RD,
    S_SCT_ST,
    S_SCT_WR,
    S_M_INIT,
    S_M_ROW,
    S_M_ROWD,
    S_M_RD,
    S_M_DEC,
    S_DONE
  } state_e;

  state_e                state_q;
  phase_e                phase_q;
  status_e               err_q;
  logic [ROWCNT_W-1:0]   row_count_q;
  logic                  sorted_cfg_q;
  logic [EW-1:0]         edge_total_q;
  logic [IDX_W-1:0]      prev_q;
  logic [PW-1:0]         ptr_q;
  logic [PW-1:0]         total_q;
  logic [NW-1:0]         rows_q;
  logic [NW-1:0]         n_q;
  logic                  sorted_q;
  logic [EW-1:0]         k_q;
  logic [EW-1:0]         pos_q;
  logic                  vld_q;
  logic [RCW-1:0]        r_q;
  logic [RA-1:0]         rr_q;
  logic [EW-1:0]         sum_a_q;
  logic [EW-1:0]         sum_t_q;
  logic                  pass_q;
  logic [RA-1:0]         ca_q;
  logic [RA-1:0]         ct_q;
  logic [IDX_W-1:0]      key_q;
  logic [PRW-1:0]        swp_q;
  logic [EW-1:0]         ap_q;
  logic [EW-1:0]         ae_q;
  logic [EW-1:0]         tp_q;
  logic [EW-1:0]         te_q;
  logic [OW-1:0]         o_q;
  logic                  have_q;
  logic [IDX_W-1:0]      last_v_q;
  logic                  fkind_q;
  logic                  valid_q;
  logic                  kind_q;
  logic [VAL_W-1:0]      value_q;
  logic                  lastw_q;
  status_e               status_q;

  // Memory ports.
  logic                e_we,   f_we,   t_we,   s_we;
  logic [EA-1:0]       e_wa,   f_wa,   t_wa,   s_wa;
  logic [EA-1:0]       e_ra,   f_ra,   t_ra,   s_ra;
  logic [PRW-1:0]      e_wd,   f_wd,   t_wd;
  logic [PRW-1:0]      e_rd,   f_rd,   t_rd;
  logic [IDX_W-1:0]    s_wd,   s_rd;
  logic                as_we,  ts_we,  ac_we,  tc_we;
  logic [RA-1:0]       as_wa,  ts_wa,  ac_wa,  tc_wa;
  logic [RA-1:0]       as_ra,  ts_ra,  ac_ra,  tc_ra;
  logic [EW-1:0]       as_wd,  ts_wd,  ac_wd,  tc_wd;
  logic [EW-1:0]       as_rd,  ts_rd,  ac_rd,  tc_rd;
  logic                ors_we, onb_we;
  logic [RA-1:0]       ors_wa, ors_ra;
  logic [OW-1:0]       ors_wd, ors_rd;
  logic [OA-1:0]       onb_wa, onb_ra;
  logic [IDX_W-1:0]    onb_wd, onb_rd;

  logic                accept;
  op_e                 op;
  logic [NW-1:0]       eff_n;
  logic                ld_fresh;
  logic [EW-1:0]       ld_total;
  logic [IDX_W-1:0]    ld_prev;
  status_e             ld_err;
  status_e             ld_code;
  logic                f_keep;
  logic [EW-1:0]       cur;
  logic [IDX_W-1:0]    av;
  logic [IDX_W-1:0]    tv;
  logic                a_has;
  logic                t_has;
  logic [IDX_W-1:0]    mv;
  logic                m_adv_a;
  logic                m_adv_t;
  logic                m_emit;
  logic [PW-1:0]       nb_idx;

  assign accept = start_i && (state_q == S_IDLE);
  assign op     = op_e'(op_i);

  // Effective row count: zero acts as one, large values clip to the store size.
  always_comb begin
    if (row_count_q == '0) begin
      eff_n = NW'(1);
    end else if (32'(row_count_q) > 32'(MAX_ROWS)) begin
      eff_n = NW'(MAX_ROWS);
    end else begin
      eff_n = NW'(row_count_q);
    end
  end

  // Load checks; a load after a compute starts a fresh graph.
  always_comb begin
    ld_fresh = (phase_q != PH_LOADING);
    ld_total = ld_fresh ? '0 : edge_total_q;
    ld_prev  = ld_fresh ? '0 : prev_q;
    ld_err   = ld_fresh ? ST_OK : err_q;
    if (32'(src_row_i) >= 32'(eff_n) || 32'(dest_col_i) >= 32'(eff_n)) begin
      ld_code = ST_RANGE;
    end else if (ld_total != '0 && src_row_i < ld_prev) begin
      ld_code = ST_ORDER;
    end else if (32'(ld_total) >= 32'(MAX_EDGES)) begin
      ld_code = ST_FULL;
    end else begin
      ld_code = ST_OK;
    end
  end

  // Filter keeps edges whose row and column both lie below the row count.
  assign f_keep = (32'(e_rd[PRW-1:IDX_W]) < 32'(n_q)) && (32'(e_rd[IDX_W-1:0]) < 32'(n_q));

  // Fill cursor of the active scatter pass.
  assign cur = pass_q ? ac_rd : tc_rd;

  // Two-pointer merge decision.
  always_comb begin
    av      = sorted_q ? f_rd[IDX_W-1:0] : s_rd;
    tv      = t_rd[IDX_W-1:0];
    a_has   = (ap_q != ae_q);
    t_has   = (tp_q != te_q);
    m_adv_a = 1'b0;
    m_adv_t = 1'b0;
    mv      = av;
    if (!a_has) begin
      mv      = tv;
      m_adv_t = 1'b1;
    end else if (!t_has) begin
      m_adv_a = 1'b1;
    end else if (av < tv) begin
      m_adv_a = 1'b1;
    end else if (tv < av) begin
      mv      = tv;
      m_adv_t = 1'b1;
    end else begin
      m_adv_a = 1'b1;
      m_adv_t = 1'b1;
    end
    m_emit = !have_q || (mv != last_v_q);
  end

  assign nb_idx = ptr_q - PW'(rows_q) - PW'(1);

  // Memory control by state.
  always_comb begin
    e_we = 1'b0;  e_wa = ld_total[EA-1:0];  e_wd = {src_row_i, dest_col_i};
    e_ra = k_q[EA-1:0];
    f_we = 1'b0;  f_wa = pos_q[EA-1:0];  f_wd = e_rd;  f_ra = k_q[EA-1:0];
    t_we = 1'b0;  t_wa = cur[EA-1:0];    t_wd = swp_q; t_ra = k_q[EA-1:0];
    s_we = 1'b0;  s_wa = cur[EA-1:0];    s_wd = swp_q[IDX_W-1:0];
    s_ra = ap_q[EA-1:0];
    as_we = 1'b0; as_wa = r_q[RA-1:0]; as_wd = '0; as_ra = r_q[RA-1:0];
    ts_we = 1'b0; ts_wa = r_q[RA-1:0]; ts_wd = '0; ts_ra = r_q[RA-1:0];
    ac_we = 1'b0; ac_wa = rr_q; ac_wd = sum_a_q + as_rd; ac_ra = RA'(key_q);
    tc_we = 1'b0; tc_wa = rr_q; tc_wd = sum_t_q + ts_rd; tc_ra = RA'(key_q);
    ors_we = 1'b0; ors_wa = '0; ors_wd = '0; ors_ra = ptr_q[RA-1:0];
    onb_we = 1'b0; onb_wa = o_q[OA-1:0]; onb_wd = mv; onb_ra = nb_idx[OA-1:0];
    unique case (state_q)
      S_IDLE: begin
        e_we = accept && (op == OP_LOAD) && (ld_code == ST_OK);
      end
      S_FILT: begin
        f_we = vld_q && f_keep;
      end
      S_CLR: begin
        as_we = 1'b1;
        ts_we = 1'b1;
      end
      S_CNT_ST: begin
        as_ra = RA'(f_rd[PRW-1:IDX_W]) + RA'(1);
        ts_ra = RA'(f_rd[IDX_W-1:0]) + RA'(1);
      end
      S_CNT_WR: begin
        as_we = 1'b1; as_wa = ca_q; as_wd = as_rd + EW'(1);
        ts_we = 1'b1; ts_wa = ct_q; ts_wd = ts_rd + EW'(1);
      end
      S_PFX: begin
        as_we = vld_q; as_wa = rr_q; as_wd = sum_a_q + as_rd;
        ts_we = vld_q; ts_wa = rr_q; ts_wd = sum_t_q + ts_rd;
        ac_we = vld_q;
        tc_we = vld_q;
      end
      S_SCT_ST: begin
        ac_ra = RA'(pass_q ? t_rd[IDX_W-1:0] : f_rd[IDX_W-1:0]);
        tc_ra = ac_ra;
      end
      S_SCT_WR: begin
        if (pass_q) begin
          s_we  = 1'b1;
          ac_we = 1'b1; ac_wa = RA'(key_q); ac_wd = cur + EW'(1);
        end else begin
          t_we  = 1'b1;
          tc_we = 1'b1; tc_wa = RA'(key_q); tc_wd = cur + EW'(1);
        end
      end
      S_M_INIT: begin
        ors_we = 1'b1;
      end
      S_M_ROW: begin
        as_ra = RA'(r_q + RCW'(1));
        ts_ra = RA'(r_q + RCW'(1));
      end
      S_M_RD: begin
        f_ra = ap_q[EA-1:0];
        t_ra = tp_q[EA-1:0];
        if (!(ap_q != ae_q || tp_q != te_q)) begin
          ors_we = 1'b1; ors_wa = RA'(r_q + RCW'(1)); ors_wd = o_q;
        end
      end
      S_M_DEC: begin
        onb_we = m_emit;
      end
      default: begin
      end
    endcase
  end

  // Control, sequencing and registered result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      phase_q      <= PH_LOADING;
      err_q        <= ST_OK;
      row_count_q  <= ROWCNT_W'(1);
      sorted_cfg_q <= 1'b0;
      edge_total_q <= '0;
      prev_q       <= '0;
      ptr_q        <= '0;
      total_q      <= '0;
      rows_q       <= NW'(1);
      vld_q        <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_ROW_COUNT: row_count_q  <= cfg_data_i;
          REG_SORTED:    sorted_cfg_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_LOAD: begin
                phase_q <= PH_LOADING;
                ptr_q   <= ld_fresh ? '0 : ptr_q;
                if (ld_code != ST_OK) begin
                  err_q        <= (ld_err == ST_OK) ? ld_code : ld_err;
                  edge_total_q <= ld_total;
                  prev_q       <= ld_prev;
                  valid_q      <= 1'b1;
                  kind_q       <= 1'b0;
                  value_q      <= '0;
                  lastw_q      <= 1'b0;
                  status_q     <= ld_code;
                end else begin
                  err_q        <= ld_err;
                  edge_total_q <= ld_total + EW'(1);
                  prev_q       <= src_row_i;
                end
              end
              OP_COMPUTE: begin
                n_q      <= eff_n;
                sorted_q <= sorted_cfg_q;
                k_q      <= '0;
                pos_q    <= '0;
                vld_q    <= 1'b0;
                state_q  <= S_FILT;
              end
              OP_FETCH: begin
                if (phase_q != PH_READY) begin
                  valid_q  <= 1'b1;
                  kind_q   <= 1'b0;
                  value_q  <= '0;
                  lastw_q  <= 1'b0;
                  status_q <= ST_NOT_READY;
                end else begin
                  fkind_q <= (ptr_q > PW'(rows_q));
                  state_q <= S_FETCH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FETCH: begin
          valid_q  <= 1'b1;
          kind_q   <= fkind_q;
          value_q  <= fkind_q ? VAL_W'(onb_rd) : VAL_W'(ors_rd);
          lastw_q  <= (ptr_q + PW'(1) >= total_q);
          status_q <= ST_OK;
          ptr_q    <= ptr_q + PW'(1);
          if (ptr_q + PW'(1) >= total_q) begin
            phase_q <= PH_DONE;
          end
          state_q <= S_IDLE;
        end
        // Stream the edge store and keep edges inside the row count.
        S_FILT: begin
          if (k_q != edge_total_q) begin
            k_q   <= k_q + EW'(1);
            vld_q <= 1'b1;
          end else begin
            vld_q <= 1'b0;
          end
          if (vld_q && f_keep) begin
            pos_q <= pos_q + EW'(1);
          end
          if (k_q == edge_total_q && !vld_q) begin
            r_q     <= '0;
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          if (r_q == RCW'(n_q)) begin
            k_q     <= '0;
            state_q <= S_CNT_RD;
          end else begin
            r_q <= r_q + RCW'(1);
          end
        end
        // Histogram of rows and columns, one read-modify-write per edge.
        S_CNT_RD: begin
          if (k_q == pos_q) begin
            r_q     <= '0;
            sum_a_q <= '0;
            sum_t_q <= '0;
            vld_q   <= 1'b0;
            state_q <= S_PFX;
          end else begin
            state_q <= S_CNT_ST;
          end
        end
        S_CNT_ST: begin
          ca_q    <= RA'(f_rd[PRW-1:IDX_W]) + RA'(1);
          ct_q    <= RA'(f_rd[IDX_W-1:0]) + RA'(1);
          state_q <= S_CNT_WR;
        end
        S_CNT_WR: begin
          k_q     <= k_q + EW'(1);
          state_q <= S_CNT_RD;
        end
        // Running sums turn counts into row starts and fill cursors.
        S_PFX: begin
          if (r_q <= RCW'(n_q)) begin
            rr_q  <= r_q[RA-1:0];
            r_q   <= r_q + RCW'(1);
            vld_q <= 1'b1;
          end else begin
            vld_q <= 1'b0;
          end
          if (vld_q) begin
            sum_a_q <= sum_a_q + as_rd;
            sum_t_q <= sum_t_q + ts_rd;
          end
          if (r_q > RCW'(n_q) && !vld_q) begin
            pass_q  <= 1'b0;
            k_q     <= '0;
            state_q <= S_SCT_RD;
          end
        end
        // Scatter: the first pass builds the transpose; unless rows are flagged sorted, the
        // second one builds the transpose of that, which is the input with each row sorted.
        S_SCT_RD: begin
          if (k_q == pos_q) begin
            if (pass_q || sorted_q) begin
              state_q <= S_M_INIT;
            end else begin
              pass_q  <= 1'b1;
              k_q     <= '0;
            end
          end else begin
            state_q <= S_SCT_ST;
          end
        end
        S_SCT_ST: begin
          key_q   <= pass_q ? t_rd[IDX_W-1:0] : f_rd[IDX_W-1:0];
          swp_q   <= pass_q ? {t_rd[IDX_W-1:0], t_rd[PRW-1:IDX_W]}
                            : {f_rd[IDX_W-1:0], f_rd[PRW-1:IDX_W]};
          state_q <= S_SCT_WR;
        end
        S_SCT_WR: begin
          k_q     <= k_q + EW'(1);
          state_q <= S_SCT_RD;
        end
        // Row-by-row merge of the input row with its transpose row.
        S_M_INIT: begin
          r_q     <= '0;
          ap_q    <= '0;
          tp_q    <= '0;
          o_q     <= '0;
          state_q <= S_M_ROW;
        end
        S_M_ROW: begin
          state_q <= (r_q == RCW'(n_q)) ? S_DONE : S_M_ROWD;
        end
        S_M_ROWD: begin
          ae_q    <= as_rd;
          te_q    <= ts_rd;
          have_q  <= 1'b0;
          state_q <= S_M_RD;
        end
        S_M_RD: begin
          if (ap_q != ae_q || tp_q != te_q) begin
            state_q <= S_M_DEC;
          end else begin
            r_q     <= r_q + RCW'(1);
            state_q <= S_M_ROW;
          end
        end
        S_M_DEC: begin
          if (m_adv_a) begin
            ap_q <= ap_q + EW'(1);
          end
          if (m_adv_t) begin
            tp_q <= tp_q + EW'(1);
          end
          if (m_emit) begin
            o_q      <= o_q + OW'(1);
            last_v_q <= mv;
            have_q   <= 1'b1;
          end
          state_q <= S_M_RD;
        end
        S_DONE: begin
          valid_q  <= 1'b1;
          kind_q   <= 1'b0;
          value_q  <= VAL_W'(o_q);
          lastw_q  <= 1'b0;
          status_q <= err_q;
          rows_q   <= n_q;
          total_q  <= PW'(n_q) + PW'(1) + PW'(o_q);
          ptr_q    <= '0;
          phase_q  <= PH_READY;
          state_q  <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign word_kind_o  = kind_q;
  assign word_value_o = value_q;
  assign last_word_o  = lastw_q;
  assign status_o     = status_q;

  // Loaded edges as {row, column}.
  csym_ram #(.WIDTH(PRW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_wa), .wdata_i(e_wd), .raddr_i(e_ra), .rdata_o(e_rd)
  );

  // Kept edges as {row, column}.
  csym_ram #(.WIDTH(PRW), .DEPTH(MAX_EDGES)) u_keep_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd)
  );

  // Transpose edges as {column, row}, sorted by row within each column.
  csym_ram #(.WIDTH(PRW), .DEPTH(MAX_EDGES)) u_tnb_ram (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd)
  );

  // Sorted input neighbors.
  csym_ram #(.WIDTH(IDX_W), .DEPTH(MAX_EDGES)) u_snb_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd)
  );

  csym_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS + 1)) u_astart_ram (
    .clk_i, .we_i(as_we), .waddr_i(as_wa), .wdata_i(as_wd), .raddr_i(as_ra), .rdata_o(as_rd)
  );

  csym_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS + 1)) u_tstart_ram (
    .clk_i, .we_i(ts_we), .waddr_i(ts_wa), .wdata_i(ts_wd), .raddr_i(ts_ra), .rdata_o(ts_rd)
  );

  csym_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS + 1)) u_acur_ram (
    .clk_i, .we_i(ac_we), .waddr_i(ac_wa), .wdata_i(ac_wd), .raddr_i(ac_ra), .rdata_o(ac_rd)
  );

  csym_ram #(.WIDTH(EW), .DEPTH(MAX_ROWS + 1)) u_tcur_ram (
    .clk_i, .we_i(tc_we), .waddr_i(tc_wa), .wdata_i(tc_wd), .raddr_i(tc_ra), .rdata_o(tc_rd)
  );

  csym_ram #(.WIDTH(OW), .DEPTH(MAX_ROWS + 1)) u_ors_ram (
    .clk_i, .we_i(ors_we), .waddr_i(ors_wa), .wdata_i(ors_wd), .raddr_i(ors_ra),
    .rdata_o(ors_rd)
  );

  csym_ram #(.WIDTH(IDX_W), .DEPTH(2 * MAX_EDGES)) u_onb_ram (
    .clk_i, .we_i(onb_we), .waddr_i(onb_wa), .wdata_i(onb_wd), .raddr_i(onb_ra),
    .rdata_o(onb_rd)
  );

endmodule

>>> rtl/csym_checker.sv
`include "csr_graph_symmetrize_core_assert.svh"

module csym_checker import csym_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic [OP_W-1:0]   op_i,
  input logic              valid_o,
  input logic              word_kind_o,
  input logic [VAL_W-1:0]  word_value_o,
  input logic              last_word_o,
  input logic [STAT_W-1:0] status_o
);

  logic acc;
  assign acc = start_i && !busy_o;

  // An accepted compute always holds the command side off in the cycle after it.
  `CSYM_ASSERT_NXT(a_compute_busy, clk_i, rst_ni, acc && op_i == OP_COMPUTE, busy_o)

  // A load never starts a multi-cycle sequence.
  `CSYM_ASSERT_NXT(a_load_free, clk_i, rst_ni, acc && op_i == OP_LOAD, !busy_o)

  // The final beat of a readout always carries a good status.
  `CSYM_ASSERT_IMP(a_last_ok, clk_i, rst_ni, valid_o && last_word_o, status_o == ST_OK)

  // A refused fetch carries an empty row-pointer beat.
  `CSYM_ASSERT_IMP(a_refused_empty, clk_i, rst_ni, valid_o && status_o == ST_NOT_READY,
    word_value_o == '0 && !last_word_o && !word_kind_o)

endmodule

bind csr_graph_symmetrize_core csym_checker u_csym_checker (.*);
